// ===== rtl/core/ook_frame_serializer_assert.svh =====
// Assertion macros for the on-off-keying frame serializer.
// Expects clk and rst_n in scope at the point of use.
`ifndef OOK_FRAME_SERIALIZER_ASSERT_SVH
`define OOK_FRAME_SERIALIZER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define OFS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ofs assertion failed");

// Next-cycle implication, disabled while in reset
`define OFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ofs assertion failed");

`endif

// ===== rtl/core/ofs_pkg.sv =====
// Shared types and constants for the on-off-keying frame serializer.
// No dependencies; imported by every module of the block.
package ofs_pkg;

    // Default message store capacity in bytes
    localparam int MAX_MESSAGE_BYTES_DEF = 64;

    // Slot timing of the frame
    localparam int SLOT_W          = 5;
    localparam int SLOTS_PER_BYTE  = 16;
    localparam int START_LAST_SLOT = 15;
    localparam int TAIL_SLOTS      = 2;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Frame phases, one-hot
    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_MSG   = 4'b0100,
        PH_TAIL  = 4'b1000
    } phase_t;

    // One input item
    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // Engine status for checking
    typedef struct packed {
        logic frame_busy;
        logic phase_start;
        logic slot_zero;
    } engine_status_t;

endpackage

// ===== rtl/core/ofs_in_reg.sv =====
// Input register of the frame serializer: holds one accepted item.
// Depends on ofs_pkg for the item type.
module ofs_in_reg
    import ofs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    input  logic  take,
    output logic  s1_valid,
    output item_t s1_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Stall only when the held item cannot move on this cycle
    assign in_stall = valid_reg && !take;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

// ===== rtl/core/ofs_engine.sv =====
// Frame engine: message store, load and frame state, slot level and result register.
// Depends on ofs_pkg for types, phases and slot timing.
module ofs_engine
    import ofs_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s1_valid,
    input  item_t          s1_item,
    output logic           take,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           led_level,
    output logic           frame_end,
    output logic           overflow_seen,
    output engine_status_t status
);

    localparam int CNT_W  = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int ADDR_W = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_MESSAGE_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_BYTE_LAST  = SLOT_W'(SLOTS_PER_BYTE - 1);
    localparam logic [SLOT_W-1:0] SLOT_START_LAST = SLOT_W'(START_LAST_SLOT);
    localparam logic [SLOT_W-1:0] SLOT_TAIL_LAST  = SLOT_W'(TAIL_SLOTS - 1);

    // Message store and its registered read
    logic [7:0]        store_mem [MAX_MESSAGE_BYTES];
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Control state
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [CNT_W-1:0]  message_length_reg, message_length_next;
    logic              zero_found_reg, zero_found_next;
    logic              frame_busy_reg, frame_busy_next;
    phase_t            frame_phase_reg, frame_phase_next;
    logic [SLOT_W-1:0] slot_counter_reg, slot_counter_next;
    logic [CNT_W-1:0]  byte_pointer_reg, byte_pointer_next;
    logic              overflow_flag_reg, overflow_flag_next;

    // Result register
    logic out_valid_reg;
    logic led_level_reg, led_level_next;
    logic frame_end_reg, frame_end_next;
    logic overflow_seen_reg, overflow_seen_next;

    logic       out_free;
    logic       is_load;
    logic       do_load;
    logic       do_tick;
    logic [7:0] cur_byte;
    logic       bit_level;
    logic       zf_tmp;
    logic [CNT_W-1:0] len_tmp;
    logic [CNT_W-1:0] cnt_tmp;
    logic [CNT_W-1:0] ptr_inc;

    assign out_free = !out_valid_reg || !out_stall;
    assign is_load  = (s1_item.req_type == REQ_LOAD);
    // Loads never need the result slot
    assign take     = s1_valid && (is_load || out_free);
    assign do_load  = take && is_load && !frame_busy_reg;
    assign do_tick  = take && !is_load;

    assign wr_en   = do_load && (load_count_reg < MAX_CNT);
    assign wr_addr = load_count_reg[ADDR_W-1:0];
    // Prefetch the byte the pointer will name next cycle
    assign rd_addr = (byte_pointer_next < MAX_CNT) ? byte_pointer_next[ADDR_W-1:0]
                                                   : '0;

    // Length byte or stored byte, MSB first, low then bit value
    assign cur_byte  = (frame_phase_reg == PH_LEN) ? 8'(message_length_reg) : rd_data_reg;
    assign bit_level = slot_counter_reg[0] && cur_byte[~slot_counter_reg[3:1]];
    assign ptr_inc   = byte_pointer_reg + CNT_W'(1);

    // Next state for loads and ticks
    always_comb
    begin
        load_count_next     = load_count_reg;
        message_length_next = message_length_reg;
        zero_found_next     = zero_found_reg;
        frame_busy_next     = frame_busy_reg;
        frame_phase_next    = frame_phase_reg;
        slot_counter_next   = slot_counter_reg;
        byte_pointer_next   = byte_pointer_reg;
        overflow_flag_next  = overflow_flag_reg;
        led_level_next      = 1'b0;
        frame_end_next      = 1'b0;
        overflow_seen_next  = overflow_flag_reg;
        zf_tmp              = zero_found_reg;
        len_tmp             = message_length_reg;
        cnt_tmp             = load_count_reg;

        if (do_load)
        begin
            // Store the byte, or drop it and flag overflow
            if (load_count_reg < MAX_CNT)
            begin
                if ((s1_item.data_byte == 8'd0) && !zero_found_reg)
                begin
                    zf_tmp  = 1'b1;
                    len_tmp = load_count_reg;
                end
                cnt_tmp = load_count_reg + CNT_W'(1);
            end
            else
            begin
                overflow_flag_next = 1'b1;
            end
            load_count_next     = cnt_tmp;
            zero_found_next     = zf_tmp;
            message_length_next = len_tmp;
            // Start the frame on the last byte
            if (s1_item.last_byte)
            begin
                message_length_next = zf_tmp ? len_tmp : cnt_tmp;
                load_count_next     = '0;
                zero_found_next     = 1'b0;
                frame_busy_next     = 1'b1;
                frame_phase_next    = PH_START;
                slot_counter_next   = '0;
                byte_pointer_next   = '0;
            end
        end
        else if (do_tick && frame_busy_reg)
        begin
            slot_counter_next = slot_counter_reg + SLOT_W'(1);
            case (frame_phase_reg)
                PH_START:
                begin
                    led_level_next = (slot_counter_reg == '0) ||
                                     (slot_counter_reg == SLOT_START_LAST);
                    if (slot_counter_reg == SLOT_BYTE_LAST)
                    begin
                        slot_counter_next = '0;
                        frame_phase_next  = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    led_level_next = bit_level;
                    if (slot_counter_reg == SLOT_BYTE_LAST)
                    begin
                        slot_counter_next = '0;
                        byte_pointer_next = '0;
                        frame_phase_next  = (message_length_reg == '0) ? PH_TAIL : PH_MSG;
                    end
                end
                PH_MSG:
                begin
                    led_level_next = bit_level;
                    if (slot_counter_reg == SLOT_BYTE_LAST)
                    begin
                        slot_counter_next = '0;
                        byte_pointer_next = ptr_inc;
                        if (ptr_inc >= message_length_reg)
                        begin
                            frame_phase_next = PH_TAIL;
                        end
                    end
                end
                default:
                begin
                    // Tail lows; the second one ends the frame
                    if (slot_counter_reg == SLOT_TAIL_LAST)
                    begin
                        frame_end_next     = 1'b1;
                        frame_busy_next    = 1'b0;
                        frame_phase_next   = PH_START;
                        slot_counter_next  = '0;
                        byte_pointer_next  = '0;
                        overflow_flag_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // Write and read the message store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= s1_item.data_byte;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg     <= '0;
            message_length_reg <= '0;
            zero_found_reg     <= 1'b0;
            frame_busy_reg     <= 1'b0;
            frame_phase_reg    <= PH_START;
            slot_counter_reg   <= '0;
            byte_pointer_reg   <= '0;
            overflow_flag_reg  <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            load_count_reg     <= load_count_next;
            message_length_reg <= message_length_next;
            zero_found_reg     <= zero_found_next;
            frame_busy_reg     <= frame_busy_next;
            frame_phase_reg    <= frame_phase_next;
            slot_counter_reg   <= slot_counter_next;
            byte_pointer_reg   <= byte_pointer_next;
            overflow_flag_reg  <= overflow_flag_next;
            if (out_free)
            begin
                out_valid_reg <= do_tick;
            end
        end
    end

    // Load the result payload when a tick moves in
    always_ff @(posedge clk)
    begin
        if (do_tick)
        begin
            led_level_reg     <= led_level_next;
            frame_end_reg     <= frame_end_next;
            overflow_seen_reg <= overflow_seen_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign led_level     = led_level_reg;
    assign frame_end     = frame_end_reg;
    assign overflow_seen = overflow_seen_reg;

    assign status.frame_busy  = frame_busy_reg;
    assign status.phase_start = (frame_phase_reg == PH_START);
    assign status.slot_zero   = (slot_counter_reg == '0);

endmodule

// ===== rtl/core/ook_frame_serializer.sv =====
// Return-to-zero on-off-keying frame serializer, top level.
// A tick item's level passes through the input register and then the result register.
// Throughput: one item per cycle, loads and ticks alike, set by the single-pass engine; ticks wait on out_stall.
// Reset (rst_n, asynchronous, active low) clears counters, flags and valids; the store is not cleared.
// Depends on ofs_pkg, ofs_in_reg, ofs_engine and ook_frame_serializer_assert.svh.
`include "ook_frame_serializer_assert.svh"
module ook_frame_serializer
    import ofs_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       led_level,
    output logic       frame_end,
    output logic       overflow_seen
);

    item_t          in_item;
    item_t          s1_item;
    logic           s1_valid;
    logic           take;
    engine_status_t status;

    assign in_item.req_type  = req_type;
    assign in_item.data_byte = data_byte;
    assign in_item.last_byte = last_byte;

    // Hold the accepted item
    ofs_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .take     (take),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    // Run the frame and register the result
    ofs_engine #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_item       (s1_item),
        .take          (take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .led_level     (led_level),
        .frame_end     (frame_end),
        .overflow_seen (overflow_seen),
        .status        (status)
    );

    // Checks
    `OFS_ASSERT_IMPL(a_end_slot_low, out_valid && frame_end, !led_level)
    `OFS_ASSERT_IMPL(a_idle_rewound, !status.frame_busy, status.phase_start && status.slot_zero)
    `OFS_ASSERT_NEXT(a_accept_held, in_valid && !in_stall, s1_valid)

endmodule
